/* rtl/mi4_pkg.sv */
// Shared types, defaults and index helpers for the 4x4 matrix inverter.
// Used by matrix_inverse_4x4 and tb_top; depends on nothing else.
`timescale 1ns / 1ps

package mi4_pkg;

    localparam int ELEM_BITS      = 32;  // width of the value field on the ports
    localparam int DEF_WORD_BITS  = 32;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int S_TDATA_BITS   = 40;  // row, col, value padded to bytes
    localparam int M_TDATA_BITS   = 40;
    localparam int M_TUSER_BITS   = 2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TA,     // first element of a triple product
        ST_TB,     // second element, first multiply
        ST_TC,     // third element, set up the wide multiply
        ST_MUL,    // one chunk times the scalar
        ST_MACC,   // fold the chunk product into the partial sum
        ST_TSUM,   // add or subtract the triple into the cofactor
        ST_CST,    // store the finished cofactor
        ST_DRD,    // read a first-column cofactor
        ST_DLD,    // set up cofactor times row-zero element
        ST_DADD,   // accumulate into the determinant
        ST_DFIN,   // determinant magnitude and sign
        ST_ERD,    // read the cofactor of the next result
        ST_ELD,    // set up the divider
        ST_DIV,    // one quotient bit per cycle
        ST_FIN,    // saturate and load the output register
        ST_OUT     // wait for the result to be taken
    } t_state;

    // x-th index of 0..3 with k left out
    function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] x);
        skip_idx = (x < k) ? x : x + 2'd1;
    endfunction

    // Column order of the six terms of a 3x3 determinant; the first three
    // are even permutations and the last three odd.
    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] e);
        logic [5:0] row;
        case (p)
            3'd0:    row = 6'b10_01_00;
            3'd1:    row = 6'b00_10_01;
            3'd2:    row = 6'b01_00_10;
            3'd3:    row = 6'b01_10_00;
            3'd4:    row = 6'b10_00_01;
            3'd5:    row = 6'b00_01_10;
            default: row = 6'b10_01_00;
        endcase
        case (e)
            2'd0:    perm_col = row[1:0];
            2'd1:    perm_col = row[3:2];
            default: perm_col = row[5:4];
        endcase
    endfunction

endpackage

/* rtl/matrix_inverse_4x4.sv */
// Top level of the 4x4 fixed-point matrix inverter (adjugate method).
// Depends on mi4_pkg for the state type, defaults and index helpers.
`timescale 1ns / 1ps

// Elements are loaded one request per cycle into a 16-entry store; the request
// flagged last stores its element and starts an inversion, and the block then
// holds o_s_tready low until all 16 results have been taken. All arithmetic
// goes through one WORD_BITS x WORD_BITS multiplier and one bit-serial
// restoring divider. Each of the 16 cofactors is a sum of 6 terms, each term
// worked in NCH = 4 chunks, and each result's division runs over NB dividend
// bits, with NB = 3*WORD_BITS+4+2*FRAC_BITS (NB = 132 at Q16.16).
// A singular matrix skips the divisions. Results come out in row-major order.
module matrix_inverse_4x4 #(
    parameter int WORD_BITS = mi4_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = mi4_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // row[1:0], col[3:2], value[35:4], zero[39:36]
    input  logic [mi4_pkg::S_TDATA_BITS-1:0]  i_s_tdata,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // out_row[1:0], out_col[3:2], out_value[35:4], zero[39:36]
    output logic [mi4_pkg::M_TDATA_BITS-1:0]  o_m_tdata,
    // singular[0], saturated[1]
    output logic [mi4_pkg::M_TUSER_BITS-1:0]  o_m_tuser,
    output logic                              o_m_tlast
);
    import mi4_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int CW    = 3 * WORD_BITS + 4;           // cofactor width
    localparam int DW    = 4 * WORD_BITS + 4;           // determinant width
    localparam int NCH   = (CW + WORD_BITS - 1) / WORD_BITS;
    localparam int CHW   = $clog2(NCH);
    localparam int PARTW = (NCH + 1) * WORD_BITS;
    localparam int NB    = CW + 2 * FRAC_BITS;          // dividend bits
    localparam int CNTW  = $clog2(NB + 1);

    t_state r_state, n_state;

    logic [W-1:0]          r_mat [16];
    logic [CW-1:0]         r_cof [16];
    logic [CW-1:0]         r_cof_rd;

    logic [1:0]            r_i, r_j, r_k;
    logic [2:0]            r_p;
    logic [CHW-1:0]        r_chunk;
    logic                  r_for_det;
    logic [W-1:0]          r_ma;
    logic [W-1:0]          r_mul_m;
    logic                  r_sg;
    logic [2*W-1:0]        r_mp;
    logic [NCH*W-1:0]      r_wv;
    logic [PARTW-1:0]      r_part;
    logic signed [DW-1:0]  r_acc;
    logic [DW-1:0]         r_den;
    logic                  r_dneg;
    logic                  r_sing;
    logic [NB-1:0]         r_num;
    logic [DW-1:0]         r_rem;
    logic [W-1:0]          r_q;
    logic                  r_big;
    logic                  r_qneg;
    logic [CNTW-1:0]       r_cnt;

    logic                  r_o_valid;
    logic [1:0]            r_o_row, r_o_col;
    logic [ELEM_BITS-1:0]  r_o_value;
    logic                  r_o_sing, r_o_sat, r_o_last;

    logic                  in_fire, out_fire;
    logic [1:0]            sel_e;
    logic [3:0]            mat_addr;
    logic [W-1:0]          elem, elem_mag;
    logic                  elem_neg;
    logic [W-1:0]          mul_a, mul_b;
    logic [2*W-1:0]        mul_y;
    logic signed [CW-1:0]  cof_s;
    logic [CW-1:0]         cof_mag;
    logic [3:0]            cof_raddr;
    logic [DW:0]           trial;
    logic                  q_bit;
    logic [W-1:0]          lim, fin_mag;
    logic signed [W-1:0]   fin_val;
    logic                  fin_over;

    assign in_fire  = i_s_tvalid && o_s_tready;
    assign out_fire = r_o_valid && i_m_tready;

    // Element read: the cofactor phase walks the 3x3 minor, the determinant
    // phase walks row zero.
    always_comb begin
        case (r_state)
            ST_TA:   sel_e = 2'd0;
            ST_TB:   sel_e = 2'd1;
            default: sel_e = 2'd2;
        endcase
        if (r_state == ST_DLD) begin
            mat_addr = {2'b00, r_k};
        end else begin
            mat_addr = {skip_idx(r_j, sel_e), skip_idx(r_i, perm_col(r_p, sel_e))};
        end
        elem     = r_mat[mat_addr];
        elem_neg = elem[W-1];
        elem_mag = elem_neg ? (~elem + W'(1)) : elem;
    end

    always_comb begin
        if (r_state == ST_TB) begin
            mul_a = r_ma;
            mul_b = elem_mag;
        end else begin
            mul_a = r_wv[r_chunk * W +: W];
            mul_b = r_mul_m;
        end
        mul_y = mul_a * mul_b;
    end

    always_comb begin
        cof_s   = signed'(r_cof_rd);
        cof_mag = cof_s[CW-1] ? CW'(-cof_s) : r_cof_rd;
        cof_raddr = (r_state == ST_DRD) ? {r_k, 2'b00} : {r_i, r_j};
        trial   = {r_rem, r_num[NB-1]};
        q_bit   = (trial >= {1'b0, r_den});
        lim     = {1'b1, {(W-1){1'b0}}} - W'(!r_qneg);
        fin_over = r_big || (r_q > lim);
        fin_mag = fin_over ? lim : r_q;
        fin_val = r_qneg ? signed'(-fin_mag) : signed'(fin_mag);
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: if (in_fire && i_s_tlast) n_state = ST_TA;
            ST_TA:   n_state = ST_TB;
            ST_TB:   n_state = ST_TC;
            ST_TC:   n_state = ST_MUL;
            ST_MUL:  n_state = ST_MACC;
            ST_MACC: begin
                if (r_chunk != '0) n_state = ST_MUL;
                else if (r_for_det) n_state = ST_DADD;
                else n_state = ST_TSUM;
            end
            ST_TSUM: n_state = (r_p == 3'd5) ? ST_CST : ST_TA;
            ST_CST:  n_state = ({r_i, r_j} == 4'hF) ? ST_DRD : ST_TA;
            ST_DRD:  n_state = ST_DLD;
            ST_DLD:  n_state = ST_MUL;
            ST_DADD: n_state = (r_k == 2'd3) ? ST_DFIN : ST_DRD;
            ST_DFIN: n_state = ST_ERD;
            ST_ERD:  n_state = r_sing ? ST_OUT : ST_ELD;
            ST_ELD:  n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CNTW'(1)) n_state = ST_FIN;
            ST_FIN:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_fire) n_state = ({r_i, r_j} == 4'hF) ? ST_IDLE : ST_ERD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Element store, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 16; n++) r_mat[n] <= '0;
        end else if (in_fire) begin
            r_mat[{i_s_tdata[1:0], i_s_tdata[3:2]}] <= i_s_tdata[4 +: W];
        end
    end

    // Cofactor memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CST) begin
            r_cof[{r_i, r_j}] <= ((r_i[0] ^ r_j[0]) ? CW'(-r_acc) : CW'(r_acc));
        end
        r_cof_rd <= r_cof[cof_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_FIN || (r_state == ST_ERD && r_sing)) begin
            r_o_valid <= 1'b1;
        end else if (out_fire) begin
            r_o_valid <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_i   <= 2'd0;
                r_j   <= 2'd0;
                r_p   <= 3'd0;
                r_acc <= '0;
            end
            ST_TA: begin
                r_ma <= elem_mag;
                r_sg <= elem_neg ^ (r_p >= 3'd3);
            end
            ST_TB: begin
                r_mp <= mul_y;
                r_sg <= r_sg ^ elem_neg;
            end
            ST_TC: begin
                r_mul_m   <= elem_mag;
                r_sg      <= r_sg ^ elem_neg;
                r_wv      <= (NCH*W)'(r_mp);
                r_part    <= '0;
                r_chunk   <= CHW'(NCH - 1);
                r_for_det <= 1'b0;
            end
            ST_MUL:  r_mp <= mul_y;
            ST_MACC: begin
                r_part <= (r_part << W) + PARTW'(r_mp);
                if (r_chunk != '0) r_chunk <= r_chunk - CHW'(1);
            end
            ST_TSUM: begin
                if (r_sg) r_acc <= r_acc - signed'(r_part[DW-1:0]);
                else      r_acc <= r_acc + signed'(r_part[DW-1:0]);
                r_p <= r_p + 3'd1;
            end
            ST_CST: begin
                r_acc <= '0;
                r_p   <= 3'd0;
                r_k   <= 2'd0;
                {r_i, r_j} <= {r_i, r_j} + 4'd1;
            end
            ST_DLD: begin
                r_wv      <= (NCH*W)'(cof_mag);
                r_mul_m   <= elem_mag;
                r_sg      <= cof_s[CW-1] ^ elem_neg;
                r_part    <= '0;
                r_chunk   <= CHW'(NCH - 1);
                r_for_det <= 1'b1;
            end
            ST_DADD: begin
                if (r_sg) r_acc <= r_acc - signed'(r_part[DW-1:0]);
                else      r_acc <= r_acc + signed'(r_part[DW-1:0]);
                r_k <= r_k + 2'd1;
            end
            ST_DFIN: begin
                r_sing <= (r_acc == '0);
                r_dneg <= r_acc[DW-1];
                r_den  <= r_acc[DW-1] ? DW'(-r_acc) : DW'(r_acc);
                r_i    <= 2'd0;
                r_j    <= 2'd0;
            end
            ST_ERD: begin
                if (r_sing) begin
                    r_o_row   <= r_i;
                    r_o_col   <= r_j;
                    r_o_value <= '0;
                    r_o_sing  <= 1'b1;
                    r_o_sat   <= 1'b0;
                    r_o_last  <= ({r_i, r_j} == 4'hF);
                end
            end
            ST_ELD: begin
                r_num  <= {cof_mag, {(2*FRAC_BITS){1'b0}}};
                r_qneg <= cof_s[CW-1] ^ r_dneg;
                r_rem  <= '0;
                r_q    <= '0;
                r_big  <= 1'b0;
                r_cnt  <= CNTW'(NB);
            end
            ST_DIV: begin
                // The remainder stays below the divisor, so DW bits hold it.
                r_rem <= q_bit ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                r_q   <= {r_q[W-2:0], q_bit};
                r_big <= r_big | r_q[W-1];
                r_num <= r_num << 1;
                r_cnt <= r_cnt - CNTW'(1);
            end
            ST_FIN: begin
                r_o_row   <= r_i;
                r_o_col   <= r_j;
                r_o_value <= ELEM_BITS'(fin_val);
                r_o_sing  <= 1'b0;
                r_o_sat   <= fin_over;
                r_o_last  <= ({r_i, r_j} == 4'hF);
            end
            ST_OUT: begin
                if (out_fire) {r_i, r_j} <= {r_i, r_j} + 4'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {4'b0000, r_o_value, r_o_col, r_o_row};
    assign o_m_tuser  = {r_o_sat, r_o_sing};
    assign o_m_tlast  = r_o_last;

endmodule

/* dv/tb_top.sv */
// Self-checking bench for matrix_inverse_4x4: a directed table, then random loads.
// It predicts the adjugate inverse in wide integers; it depends on mi4_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import mi4_pkg::*;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SINGULAR,
        CHK_IDENTITY
    } t_check;

    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        last;
        t_check      check;
    } t_load;

    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        singular;
        logic        saturated;
        logic        last;
    } t_elem;

    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [S_TDATA_BITS-1:0] i_s_tdata;
    logic                    i_s_tlast;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [M_TDATA_BITS-1:0] o_m_tdata;
    logic [M_TUSER_BITS-1:0] o_m_tuser;
    logic                    o_m_tlast;

    logic [31:0]         mat_copy [16];
    logic signed [191:0] adj [16];
    t_elem               inverse_q [$];
    int                  n_errors;
    int                  n_results;
    int                  n_inversions;
    int                  n_singular;
    int                  n_saturated;
    bit                  quiet;
    bit                  hold_req;

    matrix_inverse_4x4 u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic signed [191:0] el(input int r, input int c);
        logic signed [191:0] v;
        v = $signed(mat_copy[r * 4 + c]);
        return v;
    endfunction

    // Adjugate entry (i,j) is the signed minor with row j and column i removed.
    function automatic logic signed [191:0] adj_entry(input int i, input int j);
        int rs [3];
        int cs [3];
        int n;
        int m;
        logic signed [191:0] d;
        n = 0;
        m = 0;
        for (int k = 0; k < 4; k++) begin
            if (k != j) begin
                rs[n] = k;
                n++;
            end
            if (k != i) begin
                cs[m] = k;
                m++;
            end
        end
        d = el(rs[0], cs[0]) * el(rs[1], cs[1]) * el(rs[2], cs[2])
          + el(rs[0], cs[1]) * el(rs[1], cs[2]) * el(rs[2], cs[0])
          + el(rs[0], cs[2]) * el(rs[1], cs[0]) * el(rs[2], cs[1])
          - el(rs[0], cs[0]) * el(rs[1], cs[2]) * el(rs[2], cs[1])
          - el(rs[0], cs[1]) * el(rs[1], cs[0]) * el(rs[2], cs[2])
          - el(rs[0], cs[2]) * el(rs[1], cs[1]) * el(rs[2], cs[0]);
        return ((i + j) % 2 == 1) ? -d : d;
    endfunction

    task automatic predict_inverse();
        logic signed [191:0] det;
        logic [191:0]        num;
        logic [191:0]        den;
        logic [191:0]        quo;
        logic [191:0]        lim;
        logic                neg;
        t_elem               e;
        for (int n = 0; n < 16; n++) adj[n] = adj_entry(n / 4, n % 4);
        det = '0;
        for (int k = 0; k < 4; k++) det = det + el(0, k) * adj[k * 4];
        den = det[191] ? -det : det;
        for (int n = 0; n < 16; n++) begin
            e = '0;
            e.row  = 2'(n / 4);
            e.col  = 2'(n % 4);
            e.last = (n == 15);
            if (det == 0) begin
                e.singular = 1'b1;
            end else begin
                num = adj[n][191] ? -adj[n] : adj[n];
                quo = (num << 32) / den;
                neg = adj[n][191] ^ det[191];
                lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
                if (quo > lim) begin
                    quo = lim;
                    e.saturated = 1'b1;
                end
                e.value = neg ? 32'(-quo) : 32'(quo);
            end
            inverse_q.push_back(e);
        end
    endtask

    task automatic push_typed(input t_check chk);
        t_elem e;
        for (int n = 0; n < 16; n++) begin
            e = '0;
            e.row      = 2'(n / 4);
            e.col      = 2'(n % 4);
            e.last     = (n == 15);
            e.singular = (chk == CHK_SINGULAR);
            if (chk == CHK_IDENTITY && n % 5 == 0) e.value = ONE_Q;
            inverse_q.push_back(e);
        end
    endtask

    task automatic send_load(input t_load ld);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, ld.value, ld.col, ld.row};
        i_s_tlast  <= ld.last;
        do @(posedge i_clk); while (!o_s_tready);
        mat_copy[{ld.row, ld.col}] = ld.value;
        if (ld.last) begin
            n_inversions++;
            if (ld.check == CHK_PREDICT) predict_inverse();
            else push_typed(ld.check);
        end
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0, 1, 2: return 32'(($urandom_range(0, 8) - 4) * 65536 + $urandom_range(0, 255));
            3:       return 32'(($urandom_range(0, 4) - 2) * 65536);
            4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            5:       return 32'($urandom_range(0, 3)) - 32'd1;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request. The hold-off
    // outlasts the cofactor and determinant phases, so the first result waits.
    initial begin
        int burst;
        i_m_tready <= 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if (burst > 0) begin
                burst--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 14);
            end
            i_m_tready <= (burst == 0);
        end
    end

    always @(posedge i_clk) begin
        t_elem exp_e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (inverse_q.size() == 0) begin
                $error("result with nothing expected: tdata=%h", o_m_tdata);
                n_errors++;
            end else begin
                exp_e = inverse_q.pop_front();
                n_results++;
                if (exp_e.singular) n_singular++;
                if (exp_e.saturated) n_saturated++;
                if (o_m_tdata[1:0] !== exp_e.row) begin
                    $error("out_row: expected %0d, got %0d", exp_e.row, o_m_tdata[1:0]);
                    n_errors++;
                end
                if (o_m_tdata[3:2] !== exp_e.col) begin
                    $error("out_col: expected %0d, got %0d", exp_e.col, o_m_tdata[3:2]);
                    n_errors++;
                end
                if (o_m_tdata[35:4] !== exp_e.value) begin
                    $error("out_value: expected %h, got %h", exp_e.value, o_m_tdata[35:4]);
                    n_errors++;
                end
                if (o_m_tuser[0] !== exp_e.singular) begin
                    $error("singular: expected %b, got %b", exp_e.singular, o_m_tuser[0]);
                    n_errors++;
                end
                if (o_m_tuser[1] !== exp_e.saturated) begin
                    $error("saturated: expected %b, got %b", exp_e.saturated, o_m_tuser[1]);
                    n_errors++;
                end
                if (o_m_tlast !== exp_e.last) begin
                    $error("out_last: expected %b, got %b", exp_e.last, o_m_tlast);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        t_load plan [$];
        t_load ld;
        int    order [16];
        int    cycles;
        n_errors     = 0;
        n_results    = 0;
        n_inversions = 0;
        n_singular   = 0;
        n_saturated  = 0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        i_rst_n      <= 1'b0;
        i_s_tvalid   <= 1'b0;
        i_s_tdata    <= '0;
        i_s_tlast    <= 1'b0;
        for (int k = 0; k < 16; k++) mat_copy[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero store after reset, identity, extremes with a near-zero
        // diagonal entry that drives the inverse into saturation, then a singular one.
        plan = '{
            '{2'd0, 2'd0, 32'h0000_0000, 1'b1, CHK_SINGULAR},
            '{2'd0, 2'd0, ONE_Q,         1'b0, CHK_PREDICT},
            '{2'd1, 2'd1, ONE_Q,         1'b0, CHK_PREDICT},
            '{2'd2, 2'd2, ONE_Q,         1'b0, CHK_PREDICT},
            '{2'd3, 2'd3, ONE_Q,         1'b1, CHK_IDENTITY},
            '{2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, CHK_PREDICT},
            '{2'd1, 2'd1, 32'h8000_0000, 1'b0, CHK_PREDICT},
            '{2'd2, 2'd2, 32'h0000_0001, 1'b0, CHK_PREDICT},
            '{2'd3, 2'd0, 32'hFFFF_0000, 1'b0, CHK_PREDICT},
            '{2'd3, 2'd3, 32'hFFFF_FFFF, 1'b1, CHK_PREDICT},
            '{2'd2, 2'd2, 32'h0000_0000, 1'b1, CHK_SINGULAR}
        };
        foreach (plan[k]) send_load(plan[k]);

        // Random: complete loads in shuffled order, with stray writes and one short
        // load; the long output stall comes on the first random load.
        for (int f = 0; f < 6; f++) begin
            if (f == 1) hold_req = 1'b1;
            if (f == 5) quiet = 1'b1;
            for (int k = 0; k < 16; k++) order[k] = k;
            order.shuffle();
            for (int k = 0; k < 16; k++) begin
                if (f == 4 && k > 5) break;
                ld.row   = 2'(order[k] / 4);
                ld.col   = 2'(order[k] % 4);
                ld.value = rand_elem();
                ld.last  = 1'b0;
                ld.check = CHK_PREDICT;
                if (k == 15 || (f == 4 && k == 5)) ld.last = 1'b1;
                if (!ld.last && $urandom_range(0, 9) == 0) begin
                    ld.value = $urandom();
                    send_load(ld);
                    ld.value = rand_elem();
                end
                send_load(ld);
            end
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        cycles = 0;
        while (inverse_q.size() != 0 && cycles < 200000) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (inverse_q.size() != 0) begin
            $error("%0d results never arrived", inverse_q.size());
            n_errors++;
        end
        $display("Ran %0d inversions, %0d results checked (%0d singular, %0d clamped).",
                 n_inversions, n_results, n_singular, n_saturated);
        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mi4_pkg.sv
rtl/matrix_inverse_4x4.sv
dv/tb_top.sv
